/* hdl/euler_xyz_point_rotation_macros.svh */
// Assertion macros used by the rotation block checker.
`ifndef EULER_XYZ_POINT_ROTATION_MACROS_SVH
`define EULER_XYZ_POINT_ROTATION_MACROS_SVH

// Check a property on every clock edge outside reset.
`define EUR_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define EUR_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* hdl/eur_pkg.sv */
// Shared types, constants and tables of the Euler rotation block.
`default_nettype none
package eur_pkg;

   localparam int unsigned CordicStagesDefault = 16;
   localparam int unsigned AtanLen = 24;
   localparam int unsigned FixedLatency = 9;

   localparam logic signed [34:0] GainQ30   = 35'sd652032874;
   localparam logic signed [34:0] HalfPiQ30 = 35'sd1686629713;
   localparam logic signed [34:0] PiQ30     = 35'sd3373259426;
   localparam logic signed [27:0] TrigOne   = 28'sd16777216;

   localparam logic [29:0] ATAN_TABLE [AtanLen] = '{
      30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6,
      30'h03FEAB76, 30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55,
      30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
      30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF,
      30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
      30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F
   };

   // Payload that travels down the pipeline next to its valid bit.
   typedef struct packed {
      logic signed [35:0] x;
      logic signed [35:0] y;
      logic signed [35:0] z;
      logic signed [31:0] ctr_x;
      logic signed [31:0] ctr_y;
      logic signed [31:0] ctr_z;
      logic signed [31:0] w;
      logic [2:0]         flip;
      logic [2:0][33:0]   cor_x;
      logic [2:0][33:0]   cor_y;
      logic [2:0][34:0]   cor_z;
      logic [2:0][25:0]   cosv;
      logic [2:0][25:0]   sinv;
   } pipe_type;

   // Cycles from accepted transaction to result strobe.
   function automatic int unsigned eur_latency(input int unsigned stages);
      return stages + FixedLatency;
   endfunction

endpackage
`default_nettype wire

/* hdl/eur_cordic_stage.sv */
// One CORDIC iteration for the three angle lanes.
`default_nettype none
module eur_cordic_stage #(
   parameter int unsigned STAGE = 0
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire eur_pkg::pipe_type in_pipe,
   output logic                   out_valid,
   output eur_pkg::pipe_type      out_pipe
);
   import eur_pkg::*;

   localparam logic signed [34:0] AtanStep = 35'(ATAN_TABLE[STAGE]);

   logic              valid_ff;
   pipe_type          pipe_ff, pipe_in;
   logic signed [33:0] xv [3];
   logic signed [33:0] yv [3];
   logic signed [34:0] zv [3];

   // Rotate each lane toward zero residual angle
   always_comb begin
      pipe_in = in_pipe;
      for (int l = 0; l < 3; l++) begin
         xv[l] = $signed(in_pipe.cor_x[l]);
         yv[l] = $signed(in_pipe.cor_y[l]);
         zv[l] = $signed(in_pipe.cor_z[l]);
         if (zv[l] >= 0) begin
            pipe_in.cor_x[l] = xv[l] - (yv[l] >>> STAGE);
            pipe_in.cor_y[l] = yv[l] + (xv[l] >>> STAGE);
            pipe_in.cor_z[l] = zv[l] - AtanStep;
         end else begin
            pipe_in.cor_x[l] = xv[l] + (yv[l] >>> STAGE);
            pipe_in.cor_y[l] = yv[l] - (xv[l] >>> STAGE);
            pipe_in.cor_z[l] = zv[l] + AtanStep;
         end
      end
   end

   // Advance valid and payload
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      pipe_ff <= pipe_in;
   end

   assign out_valid = valid_ff;
   assign out_pipe  = pipe_ff;
endmodule
`default_nettype wire

/* hdl/eur_rotate.sv */
// Plane rotation: four products, then rounded difference and sum.
`default_nettype none
module eur_rotate (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire eur_pkg::pipe_type in_pipe,
   input  wire logic signed [35:0] a,
   input  wire logic signed [35:0] b,
   input  wire logic signed [25:0] c,
   input  wire logic signed [25:0] s,
   output logic                   out_valid,
   output eur_pkg::pipe_type      out_pipe,
   output logic signed [35:0]     r0,
   output logic signed [35:0]     r1
);
   import eur_pkg::*;

   logic               mul_valid_ff, sum_valid_ff;
   pipe_type           mul_pipe_ff, sum_pipe_ff;
   logic signed [61:0] ac_ff, bs_ff, bc_ff, as_ff;
   logic signed [62:0] diff_in, plus_in;
   logic signed [35:0] r0_ff, r1_ff, r0_in, r1_in;

   // Combine products and round once, ties toward plus infinity
   always_comb begin
      diff_in = 63'(ac_ff) - 63'(bs_ff) + 63'sd8388608;
      plus_in = 63'(bc_ff) + 63'(as_ff) + 63'sd8388608;
      r0_in   = 36'(diff_in >>> 24);
      r1_in   = 36'(plus_in >>> 24);
   end

   // Hold products, then rounded results
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= in_valid;
         sum_valid_ff <= mul_valid_ff;
      end
      mul_pipe_ff <= in_pipe;
      ac_ff       <= a * c;
      bs_ff       <= b * s;
      bc_ff       <= b * c;
      as_ff       <= a * s;
      sum_pipe_ff <= mul_pipe_ff;
      r0_ff       <= r0_in;
      r1_ff       <= r1_in;
   end

   assign out_valid = sum_valid_ff;
   assign out_pipe  = sum_pipe_ff;
   assign r0        = r0_ff;
   assign r1        = r1_ff;
endmodule
`default_nettype wire

/* hdl/euler_xyz_point_rotation.sv */
// Throughput: one transaction per cycle; busy is high only in reset and the cycle after it.
// The CORDIC takes one pipeline stage per iteration, so the stage count sets latency.
// Each plane rotation takes a product stage and a round stage.
// Reset clears all valid bits; no result is produced for work in flight.
`default_nettype none
module euler_xyz_point_rotation #(
   parameter int unsigned CORDIC_STAGES = eur_pkg::CordicStagesDefault
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [31:0] req_point_x,
   input  wire logic signed [31:0] req_point_y,
   input  wire logic signed [31:0] req_point_z,
   input  wire logic signed [31:0] req_point_w,
   input  wire logic signed [15:0] req_angle_x,
   input  wire logic signed [15:0] req_angle_y,
   input  wire logic signed [15:0] req_angle_z,
   input  wire logic signed [31:0] req_center_x,
   input  wire logic signed [31:0] req_center_y,
   input  wire logic signed [31:0] req_center_z,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_rot_x,
   output logic signed [31:0]      rsp_rot_y,
   output logic signed [31:0]      rsp_rot_z,
   output logic signed [31:0]      rsp_rot_w
);
   import eur_pkg::*;

   logic               busy_ff;
   logic               ent_valid_ff;
   pipe_type           ent_pipe_ff, ent_pipe_in;
   logic signed [34:0] ang [3];
   logic signed [15:0] ang_raw [3];

   logic               cor_valid [CORDIC_STAGES+1];
   pipe_type           cor_pipe  [CORDIC_STAGES+1];

   logic               post_valid_ff;
   pipe_type           post_pipe_ff, post_pipe_in;
   logic signed [33:0] fx [3];
   logic signed [33:0] fy [3];
   logic signed [27:0] rx [3];
   logic signed [27:0] ry [3];

   logic               rx_valid, ry_valid, rz_valid;
   pipe_type           rx_pipe, ry_pipe, rz_pipe, ry_in, rz_in;
   logic signed [35:0] rx_r0, rx_r1, ry_r0, ry_r1, rz_r0, rz_r1;

   logic               out_valid_ff;
   logic signed [31:0] out_x_ff, out_y_ff, out_z_ff, out_w_ff;
   logic signed [31:0] out_x_in, out_y_in, out_z_in;

   // Saturate a widened coordinate to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
      if (v > 37'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (v < -37'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   // Clamp a rounded trig value to plus or minus one
   function automatic logic signed [25:0] clamp1(input logic signed [27:0] v);
      if (v > TrigOne) begin
         return 26'(TrigOne);
      end else if (v < -TrigOne) begin
         return 26'(-TrigOne);
      end
      return v[25:0];
   endfunction

   // Entry: centre-relative point and folded angles
   always_comb begin
      ent_pipe_in       = '0;
      ang_raw[0]        = req_angle_x;
      ang_raw[1]        = req_angle_y;
      ang_raw[2]        = req_angle_z;
      ent_pipe_in.x     = 36'(req_point_x) - 36'(req_center_x);
      ent_pipe_in.y     = 36'(req_point_y) - 36'(req_center_y);
      ent_pipe_in.z     = 36'(req_point_z) - 36'(req_center_z);
      ent_pipe_in.ctr_x = req_center_x;
      ent_pipe_in.ctr_y = req_center_y;
      ent_pipe_in.ctr_z = req_center_z;
      ent_pipe_in.w     = req_point_w;
      for (int l = 0; l < 3; l++) begin
         ang[l] = $signed({{2{ang_raw[l][15]}}, ang_raw[l], 17'b0});
         ent_pipe_in.cor_x[l] = 34'(GainQ30);
         ent_pipe_in.cor_y[l] = '0;
         if (ang[l] > HalfPiQ30) begin
            ent_pipe_in.cor_z[l] = ang[l] - PiQ30;
            ent_pipe_in.flip[l]  = 1'b1;
         end else if (ang[l] < -HalfPiQ30) begin
            ent_pipe_in.cor_z[l] = ang[l] + PiQ30;
            ent_pipe_in.flip[l]  = 1'b1;
         end else begin
            ent_pipe_in.cor_z[l] = ang[l];
            ent_pipe_in.flip[l]  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         ent_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         ent_valid_ff <= start && !busy_ff;
      end
      ent_pipe_ff <= ent_pipe_in;
   end

   assign busy = busy_ff;

   // CORDIC chain, one iteration per stage
   assign cor_valid[0] = ent_valid_ff;
   assign cor_pipe[0]  = ent_pipe_ff;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      eur_cordic_stage #(.STAGE(i)) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cor_valid[i]),
         .in_pipe   (cor_pipe[i]),
         .out_valid (cor_valid[i+1]),
         .out_pipe  (cor_pipe[i+1])
      );
   end

   // Unfold, round and clamp cosine and sine
   always_comb begin
      post_pipe_in = cor_pipe[CORDIC_STAGES];
      for (int l = 0; l < 3; l++) begin
         fx[l] = $signed(cor_pipe[CORDIC_STAGES].cor_x[l]);
         fy[l] = $signed(cor_pipe[CORDIC_STAGES].cor_y[l]);
         if (cor_pipe[CORDIC_STAGES].flip[l]) begin
            fx[l] = -fx[l];
            fy[l] = -fy[l];
         end
         rx[l] = 28'((fx[l] + 34'sd32) >>> 6);
         ry[l] = 28'((fy[l] + 34'sd32) >>> 6);
         post_pipe_in.cosv[l] = clamp1(rx[l]);
         post_pipe_in.sinv[l] = clamp1(ry[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         post_valid_ff <= 1'b0;
      end else begin
         post_valid_ff <= cor_valid[CORDIC_STAGES];
      end
      post_pipe_ff <= post_pipe_in;
   end

   // Rotate about X: y, z
   eur_rotate u_rot_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (post_valid_ff),
      .in_pipe   (post_pipe_ff),
      .a         (post_pipe_ff.y),
      .b         (post_pipe_ff.z),
      .c         ($signed(post_pipe_ff.cosv[0])),
      .s         ($signed(post_pipe_ff.sinv[0])),
      .out_valid (rx_valid),
      .out_pipe  (rx_pipe),
      .r0        (rx_r0),
      .r1        (rx_r1)
   );

   always_comb begin
      ry_in   = rx_pipe;
      ry_in.y = rx_r0;
      ry_in.z = rx_r1;
   end

   // Rotate about Y: z, x
   eur_rotate u_rot_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rx_valid),
      .in_pipe   (ry_in),
      .a         (ry_in.z),
      .b         (ry_in.x),
      .c         ($signed(ry_in.cosv[1])),
      .s         ($signed(ry_in.sinv[1])),
      .out_valid (ry_valid),
      .out_pipe  (ry_pipe),
      .r0        (ry_r0),
      .r1        (ry_r1)
   );

   always_comb begin
      rz_in   = ry_pipe;
      rz_in.z = ry_r0;
      rz_in.x = ry_r1;
   end

   // Rotate about Z: x, y
   eur_rotate u_rot_z (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ry_valid),
      .in_pipe   (rz_in),
      .a         (rz_in.x),
      .b         (rz_in.y),
      .c         ($signed(rz_in.cosv[2])),
      .s         ($signed(rz_in.sinv[2])),
      .out_valid (rz_valid),
      .out_pipe  (rz_pipe),
      .r0        (rz_r0),
      .r1        (rz_r1)
   );

   // Add the centre back and saturate
   always_comb begin
      out_x_in = sat32(37'(rz_r0) + 37'(rz_pipe.ctr_x));
      out_y_in = sat32(37'(rz_r1) + 37'(rz_pipe.ctr_y));
      out_z_in = sat32(37'(rz_pipe.z) + 37'(rz_pipe.ctr_z));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= rz_valid;
      end
      out_x_ff <= out_x_in;
      out_y_ff <= out_y_in;
      out_z_ff <= out_z_in;
      out_w_ff <= rz_pipe.w;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_rot_x = out_x_ff;
   assign rsp_rot_y = out_y_ff;
   assign rsp_rot_z = out_z_ff;
   assign rsp_rot_w = out_w_ff;
endmodule
`default_nettype wire

/* hdl/eur_checker.sv */
// Port-level checker for the Euler rotation block, with its bind.
`default_nettype none
`include "euler_xyz_point_rotation_macros.svh"
module eur_checker #(
   parameter int unsigned CORDIC_STAGES = eur_pkg::CordicStagesDefault
) (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire logic signed [31:0] req_point_w,
   input wire logic               rsp_valid,
   input wire logic signed [31:0] rsp_rot_w
);
   import eur_pkg::*;

   localparam int unsigned Lat = CORDIC_STAGES + FixedLatency;

   // Drop results during and right after reset
   `EUR_ASSERT_ALWAYS(a_rst_quiet, reset |=> !rsp_valid, "result strobe after reset")
   // Busy only in the cycle after reset
   `EUR_ASSERT(a_busy_rst, busy |-> $past(reset), "busy outside reset recovery")
   // Every result comes from a transaction a fixed latency earlier
   `EUR_ASSERT(a_lat, rsp_valid |-> $past(start && !busy, Lat), "result without transaction")
   // Fourth coordinate passes through unchanged
   `EUR_ASSERT(a_w, rsp_valid |-> (rsp_rot_w == $past(req_point_w, Lat)), "w coordinate changed")
endmodule

bind euler_xyz_point_rotation eur_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_eur_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_point_w (req_point_w),
   .rsp_valid   (rsp_valid),
   .rsp_rot_w   (rsp_rot_w)
);
`default_nettype wire
